@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the RTL files that check their own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

@@ rtl/pev_pkg.sv @@
// ----------------------------------------------------------------------------
// pev_pkg
// Types and opcodes of the pointer event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pev_pkg;

  localparam logic OP_TRACK   = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  // Input item of the request channel.
  typedef struct packed {
    logic               opcode;
    logic [7:0]         buttons;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               is_delta;
    logic [31:0]        time_ms;
  } pev_in_t;

  // Result item of the event channel.
  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [7:0]         out_buttons;
    logic [31:0]        out_time_ms;
    logic               had_update;
  } pev_out_t;

  // Pointer state, as held in the current registers and in the ring.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  buttons;
    logic [31:0] time_ms;
  } pev_evt_t;

endpackage

`default_nettype wire

@@ rtl/pev_if.sv @@
// ----------------------------------------------------------------------------
// pev_if
// Valid/ready channels carrying pointer requests and consumed events.
// ----------------------------------------------------------------------------
`default_nettype none

interface pev_in_if import pev_pkg::*; ();
  logic    valid;
  logic    ready;
  pev_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pev_out_if import pev_pkg::*; ();
  logic     valid;
  logic     ready;
  pev_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/pointer_event_queue.sv @@
// ----------------------------------------------------------------------------
// pointer_event_queue: pointer state tracker with a ring of button events.
// Output: a consume transfer shows its event on the output in the next cycle.
// Throughput: 1 item per cycle while the single output slot is not stalled.
// Reset: async active low; state, indices and flags clear, ring not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pointer_event_queue import pev_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  pev_in_if.sink    in_if,
  pev_out_if.source out_if
);

  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(QUEUE_DEPTH - 1);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  pev_evt_t        cur_q, cur_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic            full_q, full_d;
  logic            pend_q, pend_d;

  // Output stage: the snapshot of the current state and the flags of the
  // consume. Ring data arrives through the RAM read register in the same
  // cycle, so the final select sits after both registers.
  logic            out_valid_q, out_valid_d;
  logic            sel_ring_q, sel_ring_d;
  logic            had_q, had_d;
  pev_evt_t        snap_q, snap_d;

  // --------------------------------------------------------------------------
  // Handshake: a new transfer is taken whenever the output slot is empty or
  // is emptied in the same cycle.
  // --------------------------------------------------------------------------
  logic accept, trk, cons;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign trk         = accept && (in_if.data.opcode == OP_TRACK);
  assign cons        = accept && (in_if.data.opcode == OP_CONSUME);

  // --------------------------------------------------------------------------
  // Track path: relative moves wrap at 16 bits, an unchanged state is ignored.
  // --------------------------------------------------------------------------
  logic [15:0]     new_x, new_y;
  logic            same, upd, push;
  logic [IdxW-1:0] wr_next, rd_next;
  pev_evt_t        new_evt;

  always_comb begin
    if (in_if.data.is_delta) begin
      new_x = 16'(in_if.data.pos_x) + cur_q.x;
      new_y = 16'(in_if.data.pos_y) + cur_q.y;
    end else begin
      new_x = 16'(in_if.data.pos_x);
      new_y = 16'(in_if.data.pos_y);
    end
  end

  assign new_evt = '{x: new_x, y: new_y, buttons: in_if.data.buttons,
                     time_ms: in_if.data.time_ms};

  assign same = (new_x == cur_q.x) && (new_y == cur_q.y) &&
                (in_if.data.buttons == cur_q.buttons);
  assign upd  = trk && !same;
  // Only button changes go to the ring, and only while there is room.
  assign push = upd && !full_q && (in_if.data.buttons != cur_q.buttons);

  assign wr_next = (wr_idx_q == IdxLast) ? '0 : wr_idx_q + 1'b1;
  assign rd_next = (rd_idx_q == IdxLast) ? '0 : rd_idx_q + 1'b1;

  // --------------------------------------------------------------------------
  // Consume path: nothing pending leaves all state alone; otherwise both
  // flags clear and the oldest entry, if any, pops. A full ring has equal
  // indices, so it reads as empty here and its entries are dropped.
  // --------------------------------------------------------------------------
  logic pending, pop;

  assign pending = full_q || pend_q;
  assign pop     = cons && pending && (rd_idx_q != wr_idx_q);

  always_comb begin
    cur_d       = cur_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    full_d      = full_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    sel_ring_d  = sel_ring_q;
    had_d       = had_q;
    snap_d      = snap_q;

    if (out_if.ready) begin
      out_valid_d = 1'b0;
    end

    if (upd) begin
      cur_d  = new_evt;
      pend_d = 1'b1;
    end
    if (push) begin
      wr_idx_d = wr_next;
      full_d   = (wr_next == rd_idx_q);
    end

    if (cons) begin
      full_d      = 1'b0;
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
      sel_ring_d  = pop;
      had_d       = pending;
      snap_d      = cur_q;
    end
    if (pop) begin
      rd_idx_d = rd_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      full_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sel_ring_q  <= 1'b0;
      had_q       <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      full_q      <= full_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      sel_ring_q  <= sel_ring_d;
      had_q       <= had_d;
    end
  end

  // Snapshot is payload only.
  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  // --------------------------------------------------------------------------
  // Event ring. Reads are issued only by a pop, so the read register holds
  // its entry for as long as the output is stalled.
  // --------------------------------------------------------------------------
  logic [$bits(pev_evt_t)-1:0] ram_rdata;
  pev_evt_t                    ring_evt;
  pev_evt_t                    res_evt;

  pev_ram #(
    .WIDTH ($bits(pev_evt_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_idx_q),
    .wdata_i (new_evt),
    .re_i    (pop),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign ring_evt = pev_evt_t'(ram_rdata);
  assign res_evt  = sel_ring_q ? ring_evt : snap_q;

  assign out_if.valid            = out_valid_q;
  assign out_if.data.out_x       = $signed(res_evt.x);
  assign out_if.data.out_y       = $signed(res_evt.y);
  assign out_if.data.out_buttons = res_evt.buttons;
  assign out_if.data.out_time_ms = res_evt.time_ms;
  assign out_if.data.had_update  = had_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_full_idx_eq, full_q |-> (rd_idx_q == wr_idx_q), "full ring with unequal indices")
  `ASSERT_CLK(a_upd_pend, upd |=> pend_q, "state update did not mark pending")
  `ASSERT_CLK(a_cons_result, cons |=> (out_valid_q && (had_q == $past(pending))), "consume result lost")
  `ASSERT_NEVER(a_push_full, push && full_q, "push into a full ring")

endmodule

`default_nettype wire

@@ rtl/pev_ram.sv @@
// ----------------------------------------------------------------------------
// pev_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
